// ===== hw/rtl/convolution_reverb_wet_dry_defines.svh =====
// ----------------------------------------------------------------------------
// convolution reverb wet/dry assertion macros
// concurrent assertion helpers; empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef CONVOLUTION_REVERB_WET_DRY_DEFINES_SVH
`define CONVOLUTION_REVERB_WET_DRY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CVR_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("cvr assertion failed");

// next-cycle implication
`define CVR_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("cvr assertion failed");

`else

`define CVR_ASSERT_IMPLY(name, clk, rst, pre, post)

`define CVR_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

// ===== hw/rtl/cvr_pkg.sv =====
// ----------------------------------------------------------------------------
// cvr_pkg
// shared types and constants of the convolution reverb block
// ----------------------------------------------------------------------------
package cvr_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int SAMPLE_FRAC    = 15;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 15;
   localparam int OUT_SHIFT      = SAMPLE_FRAC + GAIN_FRAC;
   localparam int IR_LEN_BITS    = 11;
   localparam int TAP_INDEX_BITS = 10;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [GAIN_BITS-1:0]   GAIN_ONE      = 16'h8000;
   localparam logic [GAIN_BITS-1:0]   WET_RESET     = 16'h4000;
   localparam logic [GAIN_BITS-1:0]   DRY_RESET     = 16'h8000;
   localparam logic [IR_LEN_BITS-1:0] IR_LEN_RESET  = 11'd0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WET_GAIN  = 2'd0,
      CSR_DRY_GAIN  = 2'd1,
      CSR_IR_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_TAP    = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_MIX,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic tap_wr;
      logic sample_wr;
      logic first;
      logic start;
   } mac_cmd_type;

endpackage

// ===== hw/rtl/cvr_mac.sv =====
// ----------------------------------------------------------------------------
// cvr_mac
// tap and history memories with the multiply-accumulate sequencer
// ----------------------------------------------------------------------------
module cvr_mac #(
   parameter int  MAX_TAPS = 1024,
   localparam int AW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
   localparam int CW       = $clog2(MAX_TAPS + 1),
   localparam int ACC_W    = 2 * cvr_pkg::SAMPLE_BITS + CW
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cvr_pkg::mac_cmd_type                  cmd,
   input  logic signed [cvr_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [AW-1:0]                         tap_addr,
   input  logic signed [cvr_pkg::SAMPLE_BITS-1:0] tap_value,
   input  logic [CW-1:0]                         taps,
   output logic                                  done,
   output logic signed [ACC_W-1:0]               conv
);

   localparam int SB = cvr_pkg::SAMPLE_BITS;

   logic signed [SB-1:0] tap_mem  [MAX_TAPS];
   logic signed [SB-1:0] hist_mem [MAX_TAPS];

   logic signed [SB-1:0]    tap_rd_ff, hist_rd_ff;
   logic signed [2*SB-1:0]  prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic [AW-1:0] head_ff, head_in, k_ff, k_in, ptr_ff, ptr_in;
   logic [CW-1:0] fill_ff, fill_in, fill_next, rem_ff, rem_in, count;
   logic          v1_ff, v1_in, l1_ff, l1_in, v2_ff, v2_in, l2_ff, l2_in;
   logic          done_ff, done_in, issue;

   assign issue = (rem_ff != '0);

   always_comb begin
      head_in   = head_ff;
      fill_in   = fill_ff;
      fill_next = cmd.first ? CW'(1) :
                  ((fill_ff == CW'(MAX_TAPS)) ? fill_ff : fill_ff + CW'(1));
      count     = (taps < fill_next) ? taps : fill_next;
      if (cmd.sample_wr) begin
         head_in = (head_ff == AW'(MAX_TAPS - 1)) ? '0 : head_ff + AW'(1);
         fill_in = fill_next;
      end

      rem_in = rem_ff;
      k_in   = k_ff;
      ptr_in = ptr_ff;
      if (cmd.start) begin
         rem_in = count;
         k_in   = '0;
         ptr_in = head_ff;
      end else if (issue) begin
         rem_in = rem_ff - CW'(1);
         if (rem_ff != CW'(1)) begin
            k_in   = k_ff + AW'(1);
            ptr_in = (ptr_ff == '0) ? AW'(MAX_TAPS - 1) : ptr_ff - AW'(1);
         end
      end

      v1_in   = issue;
      l1_in   = issue && (rem_ff == CW'(1));
      v2_in   = v1_ff;
      l2_in   = l1_ff;
      done_in = v2_ff && l2_ff;

      if (cmd.start) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         rem_ff  <= '0;
         v1_ff   <= 1'b0;
         l1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         l2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         rem_ff  <= rem_in;
         v1_ff   <= v1_in;
         l1_ff   <= l1_in;
         v2_ff   <= v2_in;
         l2_ff   <= l2_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      ptr_ff  <= ptr_in;
      prod_ff <= tap_rd_ff * hist_rd_ff;
      acc_ff  <= acc_in;
   end

   // tap memory
   always_ff @(posedge clock) begin
      if (cmd.tap_wr) begin
         tap_mem[tap_addr] <= tap_value;
      end
      tap_rd_ff <= tap_mem[k_ff];
   end

   // sample history ring
   always_ff @(posedge clock) begin
      if (cmd.sample_wr) begin
         hist_mem[head_ff] <= sample;
      end
      hist_rd_ff <= hist_mem[ptr_ff];
   end

   assign done = done_ff;
   assign conv = acc_ff;

endmodule

// ===== hw/rtl/cvr_mix.sv =====
// ----------------------------------------------------------------------------
// cvr_mix
// wet/dry gain, rounding and saturation over five pipelined steps
// ----------------------------------------------------------------------------
module cvr_mix #(
   parameter int ACC_W = 43
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [ACC_W-1:0]                conv,
   input  logic signed [cvr_pkg::SAMPLE_BITS-1:0] x,
   input  logic [cvr_pkg::GAIN_BITS-1:0]          wet,
   input  logic [cvr_pkg::GAIN_BITS-1:0]          dry,
   output logic                                   done,
   output logic signed [cvr_pkg::SAMPLE_BITS-1:0] out_sample
);

   localparam int SB    = cvr_pkg::SAMPLE_BITS;
   localparam int GB    = cvr_pkg::GAIN_BITS;
   localparam int LO_W  = ACC_W / 2;
   localparam int HI_W  = ACC_W - LO_W;
   localparam int LP_W  = LO_W + GB;
   localparam int HP_W  = HI_W + GB + 1;
   localparam int DP_W  = SB + GB + 1;
   localparam int TOT_W = ACC_W + GB + 2;

   localparam logic signed [TOT_W-1:0] ROUND  = TOT_W'(1) <<< (cvr_pkg::OUT_SHIFT - 1);
   localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'((1 <<< (SB - 1)) - 1);
   localparam logic signed [TOT_W-1:0] SAT_LO = -SAT_HI - TOT_W'(1);

   logic [4:0]              v_ff, v_in;
   logic [LP_W-1:0]         lo_prod_ff;
   logic signed [HI_W-1:0]  hi_ff;
   logic signed [HP_W-1:0]  hi_prod_ff;
   logic signed [DP_W-1:0]  dry_prod_ff;
   logic signed [TOT_W-1:0] sum_ff, sum_in, total_ff, total_in, shifted;
   logic signed [SB-1:0]    out_ff, out_in;

   always_comb begin
      v_in     = {v_ff[3:0], start};
      sum_in   = (TOT_W'(hi_prod_ff) <<< LO_W) + $signed(TOT_W'(lo_prod_ff));
      total_in = sum_ff + (TOT_W'(dry_prod_ff) <<< cvr_pkg::SAMPLE_FRAC) + ROUND;
      shifted  = total_ff >>> cvr_pkg::OUT_SHIFT;
      if (shifted > SAT_HI) begin
         out_in = SAT_HI[SB-1:0];
      end else if (shifted < SAT_LO) begin
         out_in = SAT_LO[SB-1:0];
      end else begin
         out_in = shifted[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_prod_ff  <= LP_W'(conv[LO_W-1:0]) * LP_W'(wet);
      dry_prod_ff <= DP_W'(x) * $signed({1'b0, dry});
      hi_ff       <= conv[ACC_W-1:LO_W];
      hi_prod_ff  <= HP_W'(hi_ff) * $signed({1'b0, wet});
      sum_ff      <= sum_in;
      total_ff    <= total_in;
      if (v_ff[3]) begin
         out_ff <= out_in;
      end
   end

   assign done       = v_ff[4];
   assign out_sample = out_ff;

endmodule

// ===== hw/rtl/convolution_reverb_wet_dry.sv =====
// ----------------------------------------------------------------------------
// convolution_reverb_wet_dry
// Mixes each audio word as dry_gain*x plus wet_gain times the direct
// convolution of the current buffer with the loaded impulse response, in
// Q1.15, rounded half up and saturated to 16 bits. A tap-load word writes one
// coefficient and gives no result. With ir_length zero an audio word passes
// through unchanged, registered straight to the output. Otherwise the single
// multiply-accumulate loop runs over n taps, n being the smaller of ir_length
// (capped at MAX_TAPS) and the number of words since the last first flag
// (capped at MAX_TAPS), reading one tap and one history entry per cycle from
// the two memories. Gains above 1.0 are clamped to 1.0. Taps used by the
// convolution must have been loaded beforehand.
// ----------------------------------------------------------------------------
`include "convolution_reverb_wet_dry_defines.svh"

module convolution_reverb_wet_dry #(
   parameter int MAX_TAPS = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_type,
   input  logic                                     req_first,
   input  logic signed [cvr_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  logic [cvr_pkg::TAP_INDEX_BITS-1:0]       req_tap_index,
   input  logic signed [cvr_pkg::SAMPLE_BITS-1:0]   req_tap_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [cvr_pkg::SAMPLE_BITS-1:0]   rsp_out_sample,
   input  logic                                     csr_wr_en,
   input  logic [cvr_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [cvr_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);

   localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW    = $clog2(MAX_TAPS + 1);
   localparam int SB    = cvr_pkg::SAMPLE_BITS;
   localparam int ACC_W = 2 * SB + CW;

   cvr_pkg::state_type   state_ff, state_in;
   cvr_pkg::mac_cmd_type mac_cmd;

   logic [cvr_pkg::GAIN_BITS-1:0]   wet_gain_ff, wet_gain_in, dry_gain_ff, dry_gain_in;
   logic [cvr_pkg::GAIN_BITS-1:0]   wet_use, dry_use;
   logic [cvr_pkg::IR_LEN_BITS-1:0] ir_length_ff, ir_length_in;
   logic [CW-1:0]                   taps;

   logic signed [SB-1:0]    x_ff, mix_out, rsp_out_sample_ff, rsp_out_sample_in;
   logic signed [ACC_W-1:0] conv;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    accept, out_free, is_tap, bypass, tap_in_range;
   logic                    mac_done, mix_start, mix_done, rsp_load, rsp_pass;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != cvr_pkg::ST_IDLE) || !out_free;
   assign accept       = req_valid && !req_stall;
   assign is_tap       = (req_type == cvr_pkg::REQ_TAP);
   assign bypass       = (ir_length_ff == '0);
   assign tap_in_range = (int'(req_tap_index) < MAX_TAPS);

   always_comb begin
      if (int'(ir_length_ff) > MAX_TAPS) begin
         taps = CW'(MAX_TAPS);
      end else begin
         taps = CW'(ir_length_ff);
      end
      wet_use = (wet_gain_ff > cvr_pkg::GAIN_ONE) ? cvr_pkg::GAIN_ONE : wet_gain_ff;
      dry_use = (dry_gain_ff > cvr_pkg::GAIN_ONE) ? cvr_pkg::GAIN_ONE : dry_gain_ff;
   end

   // register writes
   always_comb begin
      wet_gain_in  = wet_gain_ff;
      dry_gain_in  = dry_gain_ff;
      ir_length_in = ir_length_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cvr_pkg::CSR_WET_GAIN: begin
               wet_gain_in = csr_wdata;
            end
            cvr_pkg::CSR_DRY_GAIN: begin
               dry_gain_in = csr_wdata;
            end
            cvr_pkg::CSR_IR_LENGTH: begin
               ir_length_in = csr_wdata[cvr_pkg::IR_LEN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cvr_pkg::ST_IDLE: begin
            if (accept && !is_tap && !bypass) begin
               state_in = cvr_pkg::ST_CONV;
            end
         end
         cvr_pkg::ST_CONV: begin
            if (mac_done) begin
               state_in = cvr_pkg::ST_MIX;
            end
         end
         cvr_pkg::ST_MIX: begin
            if (mix_done) begin
               state_in = cvr_pkg::ST_EMIT;
            end
         end
         cvr_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = cvr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cvr_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      mac_cmd   = '0;
      mix_start = 1'b0;
      rsp_load  = 1'b0;
      rsp_pass  = 1'b0;
      case (state_ff)
         cvr_pkg::ST_IDLE: begin
            if (accept) begin
               if (is_tap) begin
                  mac_cmd.tap_wr = tap_in_range;
               end else begin
                  mac_cmd.sample_wr = 1'b1;
                  mac_cmd.first     = req_first;
                  if (bypass) begin
                     rsp_load = 1'b1;
                     rsp_pass = 1'b1;
                  end else begin
                     mac_cmd.start = 1'b1;
                  end
               end
            end
         end
         cvr_pkg::ST_CONV: begin
            mix_start = mac_done;
         end
         cvr_pkg::ST_MIX: begin
         end
         cvr_pkg::ST_EMIT: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_out_sample_in = rsp_pass ? req_sample : mix_out;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cvr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wet_gain_ff  <= cvr_pkg::WET_RESET;
         dry_gain_ff  <= cvr_pkg::DRY_RESET;
         ir_length_ff <= cvr_pkg::IR_LEN_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wet_gain_ff  <= wet_gain_in;
         dry_gain_ff  <= dry_gain_in;
         ir_length_ff <= ir_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mac_cmd.sample_wr) begin
         x_ff <= req_sample;
      end
      if (rsp_load) begin
         rsp_out_sample_ff <= rsp_out_sample_in;
      end
   end

   cvr_mac #(
      .MAX_TAPS (MAX_TAPS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .cmd       (mac_cmd),
      .sample    (req_sample),
      .tap_addr  (AW'(req_tap_index)),
      .tap_value (req_tap_value),
      .taps      (taps),
      .done      (mac_done),
      .conv      (conv)
   );

   cvr_mix #(
      .ACC_W (ACC_W)
   ) u_mix (
      .clock      (clock),
      .reset      (reset),
      .start      (mix_start),
      .conv       (conv),
      .x          (x_ff),
      .wet        (wet_use),
      .dry        (dry_use),
      .done       (mix_done),
      .out_sample (mix_out)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_out_sample_ff;

   `CVR_ASSERT_IMPLY(a_mac_done_in_conv, clock, reset, mac_done, state_ff == cvr_pkg::ST_CONV)
   `CVR_ASSERT_IMPLY(a_mix_done_in_mix, clock, reset, mix_done, state_ff == cvr_pkg::ST_MIX)
   `CVR_ASSERT_NEXT(a_start_enters_conv, clock, reset, mac_cmd.start, state_ff == cvr_pkg::ST_CONV)
   `CVR_ASSERT_IMPLY(a_load_only_when_free, clock, reset, rsp_load, !rsp_valid_ff || !rsp_stall)

endmodule

// ===== verif/tb_convolution_reverb_wet_dry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convolution_reverb_wet_dry
// Self-checking bench for the convolution reverb wet/dry mixer. Sends audio
// and tap-load words with random idle on the request side and random stall
// on the output side. A shadow of the tap store, the history ring and the
// gain registers predicts every mixed output, and each output word is
// compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_convolution_reverb_wet_dry;

   localparam int TAP_DEPTH     = 1024;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 6000;

   logic                                   clock         = 1'b0;
   logic                                   reset         = 1'b1;
   logic                                   req_valid     = 1'b0;
   logic                                   req_stall;
   logic                                   req_type      = cvr_pkg::REQ_SAMPLE;
   logic                                   req_first     = 1'b0;
   logic signed [cvr_pkg::SAMPLE_BITS-1:0] req_sample    = '0;
   logic [cvr_pkg::TAP_INDEX_BITS-1:0]     req_tap_index = '0;
   logic signed [cvr_pkg::SAMPLE_BITS-1:0] req_tap_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall     = 1'b0;
   logic signed [cvr_pkg::SAMPLE_BITS-1:0] rsp_out_sample;
   logic                                   csr_wr_en     = 1'b0;
   logic [cvr_pkg::CSR_INDEX_BITS-1:0]     csr_index     = '0;
   logic [cvr_pkg::CSR_DATA_BITS-1:0]      csr_wdata     = '0;

   // shadow of the block state
   logic [cvr_pkg::GAIN_BITS-1:0]          wet_gain_q    = cvr_pkg::WET_RESET;
   logic [cvr_pkg::GAIN_BITS-1:0]          dry_gain_q    = cvr_pkg::DRY_RESET;
   logic [cvr_pkg::IR_LEN_BITS-1:0]        ir_length_q   = cvr_pkg::IR_LEN_RESET;
   logic signed [cvr_pkg::SAMPLE_BITS-1:0] tap_mem     [TAP_DEPTH];
   logic signed [cvr_pkg::SAMPLE_BITS-1:0] history_mem [TAP_DEPTH];
   bit                                     tap_loaded  [TAP_DEPTH];
   int                                     history_fill  = 0;
   int                                     history_head  = 0;

   logic [cvr_pkg::SAMPLE_BITS-1:0]        mix_q [$];
   logic [cvr_pkg::SAMPLE_BITS-1:0]        out_want;
   int                                     error_count   = 0;
   int                                     quiet_cycles  = 0;
   int                                     rsp_hold      = 0;
   bit                                     idling_on     = 1'b1;

   convolution_reverb_wet_dry #(
      .MAX_TAPS(TAP_DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_first      (req_first),
      .req_sample     (req_sample),
      .req_tap_index  (req_tap_index),
      .req_tap_value  (req_tap_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int draw_wait();
      if (!idling_on || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic logic [cvr_pkg::SAMPLE_BITS-1:0] pick_sample();
      logic [31:0] rnd;
      rnd = $urandom;
      case (rnd[18:16])
         3'd0:    return 16'h7fff;
         3'd1:    return 16'h8000;
         default: return rnd[15:0];
      endcase
   endfunction

   function automatic logic [cvr_pkg::GAIN_BITS-1:0] pick_gain();
      logic [31:0] rnd;
      rnd = $urandom;
      case (rnd[19:17])
         3'd0:    return 16'h0000;
         3'd1:    return cvr_pkg::GAIN_ONE;
         3'd2:    return 16'hffff;
         3'd3:    return cvr_pkg::GAIN_ONE + 16'd1;
         default: return {1'b0, rnd[14:0]};
      endcase
   endfunction

   // true when every tap the next audio word would read has been loaded
   function automatic bit taps_ready(input logic first);
      int taps_used;
      int n;
      taps_used = (ir_length_q > TAP_DEPTH) ? TAP_DEPTH : int'(ir_length_q);
      n = first ? 1 : ((history_fill < TAP_DEPTH) ? history_fill + 1 : TAP_DEPTH);
      if (taps_used < n) n = taps_used;
      for (int k = 0; k < n; k++)
         if (!tap_loaded[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [cvr_pkg::SAMPLE_BITS-1:0] reverb_mix(
      input logic                                   first,
      input logic signed [cvr_pkg::SAMPLE_BITS-1:0] x
   );
      int     cur;
      int     taps_used;
      int     n;
      longint acc;
      longint wet;
      longint dry;
      longint total;
      longint mixed;
      if (first) history_fill = 0;
      cur = history_head;
      history_mem[cur] = x;
      history_head = (cur + 1) % TAP_DEPTH;
      if (history_fill < TAP_DEPTH) history_fill++;
      if (ir_length_q == '0) return x;
      taps_used = (ir_length_q > TAP_DEPTH) ? TAP_DEPTH : int'(ir_length_q);
      n = (taps_used < history_fill) ? taps_used : history_fill;
      acc = 0;
      for (int k = 0; k < n; k++)
         acc += longint'(tap_mem[k]) * longint'(history_mem[(cur + TAP_DEPTH - k) % TAP_DEPTH]);
      wet = (wet_gain_q > cvr_pkg::GAIN_ONE) ? longint'(cvr_pkg::GAIN_ONE) :
                                               longint'(wet_gain_q);
      dry = (dry_gain_q > cvr_pkg::GAIN_ONE) ? longint'(cvr_pkg::GAIN_ONE) :
                                               longint'(dry_gain_q);
      total = acc * wet + ((longint'(x) * dry) <<< cvr_pkg::SAMPLE_FRAC);
      mixed = (total + (longint'(1) <<< (cvr_pkg::OUT_SHIFT - 1))) >>> cvr_pkg::OUT_SHIFT;
      if (mixed > 32767) return 16'h7fff;
      if (mixed < -32768) return 16'h8000;
      return mixed[cvr_pkg::SAMPLE_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: %s", $realtime, msg);
   endtask

   // prediction on accepted input words, checking on accepted output words
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (csr_wr_en) quiet_cycles = 0;
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            if (req_type == cvr_pkg::REQ_TAP) begin
               tap_mem[req_tap_index]    = req_tap_value;
               tap_loaded[req_tap_index] = 1'b1;
            end else begin
               mix_q.push_back(reverb_mix(req_first, req_sample));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            rsp_hold = draw_wait();
            if (mix_q.size() == 0) begin
               report_mismatch($sformatf("out_sample %h with no word pending", rsp_out_sample));
            end else begin
               out_want = mix_q.pop_front();
               if (rsp_out_sample !== out_want)
                  report_mismatch($sformatf("out_sample got %h expected %h",
                                            rsp_out_sample, out_want));
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_word(
      input cvr_pkg::req_kind_type              kind,
      input logic                               first,
      input logic [cvr_pkg::SAMPLE_BITS-1:0]    smp,
      input logic [cvr_pkg::TAP_INDEX_BITS-1:0] tidx,
      input logic [cvr_pkg::SAMPLE_BITS-1:0]    tval
   );
      int   gap;
      logic first_used;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      // start a new buffer rather than read taps that were never loaded
      first_used = first;
      if (kind == cvr_pkg::REQ_SAMPLE && !taps_ready(first)) first_used = 1'b1;
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_first     <= first_used;
      req_sample    <= smp;
      req_tap_index <= tidx;
      req_tap_value <= tval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mix_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input cvr_pkg::csr_index_type idx,
                            input logic [cvr_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         cvr_pkg::CSR_WET_GAIN:  wet_gain_q = data;
         cvr_pkg::CSR_DRY_GAIN:  dry_gain_q = data;
         cvr_pkg::CSR_IR_LENGTH: ir_length_q = data[cvr_pkg::IR_LEN_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic test_pass_through();
      send_word(cvr_pkg::REQ_SAMPLE, 1'b1, 16'h7fff, 10'h3ff, 16'h8000);
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, 16'h8000, 10'h000, 16'h7fff);
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, 16'h0000, 10'h155, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b1, 16'hffff, 10'h2aa, pick_sample());
      settle();
   endtask

   task automatic test_tap_load();
      send_word(cvr_pkg::REQ_TAP, 1'b1, pick_sample(), 10'd0, 16'h7fff);
      send_word(cvr_pkg::REQ_TAP, 1'b0, pick_sample(), 10'd1, 16'h8000);
      send_word(cvr_pkg::REQ_TAP, 1'b1, pick_sample(), 10'd2, 16'h5555);
      send_word(cvr_pkg::REQ_TAP, 1'b0, pick_sample(), 10'd3, 16'hffff);
      send_word(cvr_pkg::REQ_TAP, 1'b0, pick_sample(), 10'h3ff, 16'haaaa);
      send_word(cvr_pkg::REQ_TAP, 1'b1, pick_sample(), 10'h200, 16'h0000);
      settle();
   endtask

   task automatic test_short_buffer();
      write_csr(cvr_pkg::CSR_IR_LENGTH, 16'd4);
      send_word(cvr_pkg::REQ_SAMPLE, 1'b1, 16'h7fff, 10'h3ff, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, 16'h8000, 10'h000, pick_sample());
      // a tap load inside a buffer leaves the history alone
      send_word(cvr_pkg::REQ_TAP, 1'b1, 16'h1234, 10'd1000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, 16'h1234, 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, pick_sample(), 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, pick_sample(), 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b1, 16'h4000, 10'h000, pick_sample());
      settle();
   endtask

   task automatic test_gains_and_saturation();
      write_csr(cvr_pkg::CSR_WET_GAIN, 16'hffff);
      write_csr(cvr_pkg::CSR_DRY_GAIN, 16'hffff);
      send_word(cvr_pkg::REQ_SAMPLE, 1'b1, 16'h7fff, 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b1, 16'h8000, 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, 16'h8000, 10'h000, pick_sample());
      settle();
      write_csr(cvr_pkg::CSR_WET_GAIN, cvr_pkg::GAIN_ONE);
      write_csr(cvr_pkg::CSR_DRY_GAIN, 16'h0000);
      send_word(cvr_pkg::REQ_SAMPLE, 1'b1, 16'h7fff, 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, 16'h7fff, 10'h000, pick_sample());
      settle();
      write_csr(cvr_pkg::CSR_WET_GAIN, 16'h0000);
      write_csr(cvr_pkg::CSR_DRY_GAIN, cvr_pkg::GAIN_ONE + 16'd1);
      write_csr(cvr_pkg::CSR_IR_LENGTH, 16'd2047);
      send_word(cvr_pkg::REQ_SAMPLE, 1'b1, 16'h8000, 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, pick_sample(), 10'h000, pick_sample());
      settle();
      write_csr(cvr_pkg::CSR_WET_GAIN, cvr_pkg::WET_RESET);
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, pick_sample(), 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, pick_sample(), 10'h000, pick_sample());
      settle();
   endtask

   task automatic test_random_traffic();
      logic [cvr_pkg::CSR_DATA_BITS-1:0]  ir_plan [9];
      logic [31:0]                        rnd;
      logic [cvr_pkg::TAP_INDEX_BITS-1:0] tidx;
      ir_plan = '{16'd0, 16'd1, 16'd3, 16'd16, 16'd64, 16'd2047, 16'd1024,
                  16'hf807, 16'd5};
      for (int k = 4; k < 64; k++)
         send_word(cvr_pkg::REQ_TAP, 1'b0, pick_sample(), k[cvr_pkg::TAP_INDEX_BITS-1:0],
                   pick_sample());
      for (int p = 0; p < 9; p++) begin
         settle();
         idling_on = (p != 4);
         write_csr(cvr_pkg::CSR_WET_GAIN, pick_gain());
         write_csr(cvr_pkg::CSR_DRY_GAIN, pick_gain());
         write_csr(cvr_pkg::CSR_IR_LENGTH, ir_plan[p]);
         for (int i = 0; i < 25; i++) begin
            rnd = $urandom;
            tidx = rnd[20] ? {4'd0, rnd[13:8]} : rnd[30:21];
            if (rnd[2:0] == 3'd0)
               send_word(cvr_pkg::REQ_TAP, rnd[3], pick_sample(), tidx, pick_sample());
            else
               send_word(cvr_pkg::REQ_SAMPLE, rnd[7:4] == 4'd0, pick_sample(), tidx,
                         pick_sample());
         end
      end
      settle();
      idling_on = 1'b1;
   endtask

   task automatic test_long_buffer();
      idling_on = 1'b0;
      write_csr(cvr_pkg::CSR_IR_LENGTH, 16'd0);
      for (int k = 64; k < 96; k++)
         send_word(cvr_pkg::REQ_TAP, 1'b0, pick_sample(), k[cvr_pkg::TAP_INDEX_BITS-1:0],
                   pick_sample());
      // fill the history past the taps in use
      for (int i = 0; i < 100; i++)
         send_word(cvr_pkg::REQ_SAMPLE, i == 0, pick_sample(), 10'h000, pick_sample());
      settle();
      idling_on = 1'b1;
      write_csr(cvr_pkg::CSR_WET_GAIN, pick_gain());
      write_csr(cvr_pkg::CSR_DRY_GAIN, pick_gain());
      write_csr(cvr_pkg::CSR_IR_LENGTH, 16'd96);
      for (int i = 0; i < 3; i++)
         send_word(cvr_pkg::REQ_SAMPLE, 1'b0, pick_sample(), 10'h000, pick_sample());
      settle();
      write_csr(cvr_pkg::CSR_IR_LENGTH, 16'd2047);
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, pick_sample(), 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b1, pick_sample(), 10'h000, pick_sample());
      send_word(cvr_pkg::REQ_SAMPLE, 1'b0, pick_sample(), 10'h000, pick_sample());
      settle();
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_pass_through();
      test_tap_load();
      test_short_buffer();
      test_gains_and_saturation();
      test_random_traffic();
      test_long_buffer();
      settle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
